### design/gwd_pkg.sv
// ----------------------------------------------------------------------------
// gwd_pkg
// Shared types, constants and calendar tables for the Gregorian weekday and
// day count block.
// ----------------------------------------------------------------------------
`default_nettype none

package gwd_pkg;

    // Days from year 0 to the start of the reference year, plus the reference
    // day of year (May 31 in a common year).
    localparam logic signed [23:0] REF_OFFSET = 24'sd736115;

    // Saturation limits of the 23-bit signed day count
    localparam logic signed [23:0] CNT_MAX = 24'sd4194303;
    localparam logic signed [23:0] CNT_MIN = -24'sd4194304;

    // Month codes used by name
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_DIFF,
        ST_MOD,
        ST_FIN,
        ST_OUT
    } gwd_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div;
        logic sum;
        logic diff;
        logic modstep;
        logic fin;
    } gwd_cmd_t;

    // floor(x / 100) for x below 25600, by multiplication with a reciprocal
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [28:0] p;
        begin
            p = {14'd0, x} * 29'd10486;
            return p[27:20];
        end
    endfunction

    // Days in the months before the given month, common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] r;
        begin
            unique case (m)
                4'd1:    r = 9'd0;
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Length of the month, common year
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        begin
            unique case (m)
                4'd2:                      r = 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7,
                4'd8, 4'd10, 4'd12:        r = 5'd31;
                default:                   r = 5'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### design/gregorian_weekday_and_day_count.sv
// Each start transfer runs six phases in order: divide, sum, difference,
// mod-7 fold, finish and output; busy is high in all six, done in output.
// Only the idle state takes a transfer, so a new date is taken only once
// the last one is through.
// Results appear for one cycle with done; the receiver cannot stall.
// Reset (rst_n low, asynchronous) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// gregorian_weekday_and_day_count
// Gregorian date to day of year, signed day count from 2015-05-31 and
// weekday, with leap year and invalid date flags.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_weekday_and_day_count
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [13:0]        year,
    input  wire logic [3:0]         month,
    input  wire logic [4:0]         day,
    output logic                    done,
    output logic [8:0]              day_of_year,
    output logic signed [22:0]      days_from_reference,
    output logic [2:0]              weekday,
    output logic                    leap_year,
    output logic                    date_invalid
);

    gwd_pkg::gwd_cmd_t  cmd;

    // Sequence the phases
    gwd_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Compute the results
    gwd_dp u_dp
    (
        .clk                 (clk),
        .cmd                 (cmd),
        .year                (year),
        .month               (month),
        .day                 (day),
        .day_of_year         (day_of_year),
        .days_from_reference (days_from_reference),
        .weekday             (weekday),
        .leap_year           (leap_year),
        .date_invalid        (date_invalid)
    );

endmodule

`default_nettype wire

### design/gwd_ctrl.sv
// ----------------------------------------------------------------------------
// gwd_ctrl
// Sequencer for the date datapath: steps through the divide, sum, difference,
// mod-7 fold and finish phases, and drives busy and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module gwd_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output gwd_pkg::gwd_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);

    gwd_pkg::gwd_state_t state_reg;
    gwd_pkg::gwd_state_t state_next;

    // Hold the current phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gwd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the phases
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = gwd_pkg::ST_DIV;
                end
            end
            gwd_pkg::ST_DIV:  state_next = gwd_pkg::ST_SUM;
            gwd_pkg::ST_SUM:  state_next = gwd_pkg::ST_DIFF;
            gwd_pkg::ST_DIFF: state_next = gwd_pkg::ST_MOD;
            gwd_pkg::ST_MOD:  state_next = gwd_pkg::ST_FIN;
            gwd_pkg::ST_FIN:  state_next = gwd_pkg::ST_OUT;
            gwd_pkg::ST_OUT:  state_next = gwd_pkg::ST_IDLE;
            default:          state_next = gwd_pkg::ST_IDLE;
        endcase
    end

    // Decode commands and handshake outputs from the phase
    always_comb
    begin
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        unique case (state_reg)
            gwd_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            gwd_pkg::ST_DIV:  cmd.div     = 1'b1;
            gwd_pkg::ST_SUM:  cmd.sum     = 1'b1;
            gwd_pkg::ST_DIFF: cmd.diff    = 1'b1;
            gwd_pkg::ST_MOD:  cmd.modstep = 1'b1;
            gwd_pkg::ST_FIN:  cmd.fin     = 1'b1;
            gwd_pkg::ST_OUT:  done        = 1'b1;
            default:          busy        = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### design/gwd_dp.sv
// ----------------------------------------------------------------------------
// gwd_dp
// Date datapath: leap rule, day of year, days before year, signed difference
// to the reference date, a folded mod-7 unit and result saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gwd_dp
(
    input  wire logic               clk,
    input  wire gwd_pkg::gwd_cmd_t  cmd,
    input  wire logic [13:0]        year,
    input  wire logic [3:0]         month,
    input  wire logic [4:0]         day,
    output logic [8:0]              day_of_year,
    output logic signed [22:0]      days_from_reference,
    output logic [2:0]              weekday,
    output logic                    leap_year,
    output logic                    date_invalid
);

    // Input capture
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    // Divide phase
    logic [7:0]  q100_reg;
    logic [7:0]  qa_reg;
    logic [7:0]  qb_reg;
    logic [22:0] p365_reg;
    logic [8:0]  offs_reg;
    logic [4:0]  mlen_reg;
    logic        mvalid_reg;

    // Sum phase
    logic        leap_reg;
    logic        bad_reg;
    logic [8:0]  doy_reg;
    logic [22:0] dby_reg;

    // Difference and mod-7 phases
    logic signed [23:0] diff_reg;
    logic [23:0]        mag_reg;
    logic [2:0]         rem_reg;

    // Results
    logic signed [22:0] count_reg;
    logic [2:0]         wd_reg;

    // Combinational terms
    logic [14:0] y_p99;
    logic [14:0] y_p399q;
    logic [12:0] y_p3q;
    logic [14:0] q100x;
    logic        leap_next;
    logic [8:0]  doy_next;
    logic        bad_next;
    logic [4:0]  lim_next;
    logic [22:0] dby_next;
    logic signed [23:0] diff_next;
    logic [5:0]  fold_sum;
    logic [3:0]  fold_mid;
    logic [2:0]  fold_low;
    logic [2:0]  rem_next;
    logic [2:0]  wd_next;
    logic signed [22:0] count_next;

    assign y_p99   = {1'b0, year_reg} + 15'd99;
    assign y_p399q = {2'b00, 13'(({1'b0, year_reg} + 15'd399) >> 2)};
    assign y_p3q   = 13'(({1'b0, year_reg} + 15'd3) >> 2);
    assign q100x   = 15'({7'd0, q100_reg} * 15'd100);

    // Leap rule: divisible by 4, and not by 100 unless by 400
    assign leap_next = (year_reg[1:0] == 2'b00)
                     && (({1'b0, year_reg} != q100x) || (q100_reg[1:0] == 2'b00));

    always_comb
    begin
        lim_next = mlen_reg + {4'd0, ((month_reg == gwd_pkg::MONTH_FEB) && leap_next)};
        bad_next = !mvalid_reg || (day_reg > lim_next);
        if (mvalid_reg)
        begin
            doy_next = offs_reg
                     + {8'd0, (leap_next && (month_reg > gwd_pkg::MONTH_FEB))}
                     + {4'd0, day_reg};
        end
        else
        begin
            doy_next = 9'd0;
        end
        dby_next = p365_reg + {10'd0, y_p3q} - {15'd0, qa_reg} + {15'd0, qb_reg};
    end

    assign diff_next = $signed({1'b0, dby_reg}) + $signed({15'd0, doy_reg})
                     - gwd_pkg::REF_OFFSET;

    // Fold the magnitude mod 7: eight is one mod 7, so add the 3-bit groups
    assign fold_sum = {3'd0, mag_reg[2:0]}   + {3'd0, mag_reg[5:3]}
                    + {3'd0, mag_reg[8:6]}   + {3'd0, mag_reg[11:9]}
                    + {3'd0, mag_reg[14:12]} + {3'd0, mag_reg[17:15]}
                    + {3'd0, mag_reg[20:18]} + {3'd0, mag_reg[23:21]};
    assign fold_mid = {1'b0, fold_sum[5:3]} + {1'b0, fold_sum[2:0]};
    assign fold_low = fold_mid[2:0] + {2'd0, fold_mid[3]};
    assign rem_next = (fold_low == 3'd7) ? 3'd0 : fold_low;

    // Weekday from the exact count, count saturated to the field range
    always_comb
    begin
        if (diff_reg[23] && (rem_reg != 3'd0))
        begin
            wd_next = 3'd7 - rem_reg;
        end
        else
        begin
            wd_next = rem_reg;
        end
        priority if (diff_reg > gwd_pkg::CNT_MAX)
        begin
            count_next = gwd_pkg::CNT_MAX[22:0];
        end
        else if (diff_reg < gwd_pkg::CNT_MIN)
        begin
            count_next = gwd_pkg::CNT_MIN[22:0];
        end
        else
        begin
            count_next = diff_reg[22:0];
        end
    end

    // Datapath registers, one group per command
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_reg  <= year;
            month_reg <= month;
            day_reg   <= day;
        end
        if (cmd.div)
        begin
            q100_reg   <= gwd_pkg::div100({1'b0, year_reg});
            qa_reg     <= gwd_pkg::div100(y_p99);
            qb_reg     <= gwd_pkg::div100(y_p399q);
            p365_reg   <= {9'd0, year_reg} * 23'd365;
            offs_reg   <= gwd_pkg::cum_days(month_reg);
            mlen_reg   <= gwd_pkg::month_len(month_reg);
            mvalid_reg <= (month_reg >= gwd_pkg::MONTH_JAN) && (month_reg <= gwd_pkg::MONTH_DEC);
        end
        if (cmd.sum)
        begin
            leap_reg <= leap_next;
            bad_reg  <= bad_next;
            doy_reg  <= doy_next;
            dby_reg  <= dby_next;
        end
        if (cmd.diff)
        begin
            diff_reg <= diff_next;
            mag_reg  <= diff_next[23] ? 24'(-diff_next) : diff_next;
        end
        if (cmd.modstep)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.fin)
        begin
            count_reg <= count_next;
            wd_reg    <= wd_next;
        end
    end

    assign day_of_year         = doy_reg;
    assign days_from_reference = count_reg;
    assign weekday             = wd_reg;
    assign leap_year           = leap_reg;
    assign date_invalid        = bad_reg;

endmodule

`default_nettype wire

### design/gwd_chk.sv
// ----------------------------------------------------------------------------
// gwd_chk
// Port-level checks on the busy/done sequencing and result ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module gwd_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [8:0]  day_of_year,
    input wire logic [2:0]  weekday
);

    // A transfer always starts work
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    // The strobe only shows up during work
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside of busy");

    // Work ends right after the strobe
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("busy or done held after result");

    // Weekday and day of year stay in range
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((weekday <= 3'd6) && (day_of_year <= 9'd366)))
        else $error("result out of range");

endmodule

bind gregorian_weekday_and_day_count gwd_chk u_gwd_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .day_of_year (day_of_year),
    .weekday     (weekday)
);

`default_nettype wire
